/* rtl/button_debounce_press_counter_defines.svh */
// Assertion macros for the button debouncer and press counter.
// Needs nothing else; included by the files that carry assertions.
`ifndef BUTTON_DEBOUNCE_PRESS_COUNTER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_COUNTER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define BDPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, off during reset.
`define BDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/bdpc_pkg.sv */
// Package for the button debouncer and press counter.
// Constants, item codes and shared types; depends on nothing.
package bdpc_pkg;

    localparam int DEBOUNCE_SAMPLES = 3;
    localparam int COUNT_LIMIT      = 7;
    localparam int TALLY_MAX        = 7;

    localparam int RUN_W   = $clog2(DEBOUNCE_SAMPLES + 1);
    localparam int TALLY_W = 3;
    localparam int AMT_W   = 8;

    localparam logic [RUN_W-1:0] RUN_TARGET = RUN_W'(DEBOUNCE_SAMPLES);
    localparam logic [TALLY_W-1:0] TALLY_CAP =
        TALLY_W'((COUNT_LIMIT < TALLY_MAX) ? COUNT_LIMIT : TALLY_MAX);

    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_DECREASE = 1'b1;

    typedef struct packed {
        logic             kind;
        logic             pin_level;
        logic [AMT_W-1:0] decrease_amount;
    } item_t;

    typedef struct packed {
        logic level;
        logic press;
    } deb_status_t;

endpackage

/* rtl/bdpc_in_if.sv */
// Input item channel: valid/ready handshake with the command payload.
// Depends on bdpc_pkg.
interface bdpc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic                       pin_level;
    logic [bdpc_pkg::AMT_W-1:0] decrease_amount;

    modport source (output valid, kind, pin_level, decrease_amount, input ready);
    modport sink (input valid, kind, pin_level, decrease_amount, output ready);
endinterface

/* rtl/bdpc_out_if.sv */
// Result item channel: valid/ready handshake with the debounced status.
// Depends on bdpc_pkg.
interface bdpc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         debounced_pressed;
    logic [bdpc_pkg::TALLY_W-1:0] press_count;
    logic                         brightness_step;

    modport source (output valid, debounced_pressed, press_count, brightness_step,
                    input ready);
    modport sink (input valid, debounced_pressed, press_count, brightness_step,
                  output ready);
endinterface

/* rtl/bdpc_cfg_if.sv */
// Configuration write channel carrying the count_mode register.
// Depends on nothing.
interface bdpc_cfg_if;
    logic valid;
    logic ready;
    logic count_mode;

    modport source (output valid, count_mode, input ready);
    modport sink (input valid, count_mode, output ready);
endinterface

/* rtl/bdpc_in_stage.sv */
// Input register stage: captures one item and holds it while the result side stalls.
// Depends on bdpc_pkg and bdpc_in_if.
module bdpc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    bdpc_in_if.sink           cmd,
    input  logic              advance,
    output logic              item_valid,
    output bdpc_pkg::item_t   item
);
    logic            valid_reg;
    logic            valid_next;
    bdpc_pkg::item_t item_reg;
    logic            take;

    assign cmd.ready  = !valid_reg || advance;
    assign take       = cmd.valid && cmd.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind            <= cmd.kind;
            item_reg.pin_level       <= cmd.pin_level;
            item_reg.decrease_amount <= cmd.decrease_amount;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

/* rtl/bdpc_debounce.sv */
// Run counters and debounced level; flags a released-to-pressed change.
// Depends on bdpc_pkg.
module bdpc_debounce (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  bdpc_pkg::item_t       item,
    output bdpc_pkg::deb_status_t status
);
    logic [bdpc_pkg::RUN_W-1:0] pressed_run_reg;
    logic [bdpc_pkg::RUN_W-1:0] pressed_run_next;
    logic [bdpc_pkg::RUN_W-1:0] released_run_reg;
    logic [bdpc_pkg::RUN_W-1:0] released_run_next;
    logic                       level_reg;
    logic                       level_next;
    logic                       press;
    logic                       tick;
    logic                       pressed;

    assign tick    = fire && (item.kind == bdpc_pkg::KIND_TICK);
    assign pressed = !item.pin_level;

    always_comb
    begin
        pressed_run_next  = pressed_run_reg;
        released_run_next = released_run_reg;
        level_next        = level_reg;
        press             = 1'b0;
        if (tick)
        begin
            if (pressed)
            begin
                released_run_next = '0;
                if (pressed_run_reg < bdpc_pkg::RUN_TARGET)
                begin
                    pressed_run_next = pressed_run_reg + bdpc_pkg::RUN_W'(1);
                    if (pressed_run_next == bdpc_pkg::RUN_TARGET)
                    begin
                        level_next = 1'b1;
                        press      = !level_reg;
                    end
                end
            end
            else
            begin
                pressed_run_next = '0;
                if (released_run_reg < bdpc_pkg::RUN_TARGET)
                begin
                    released_run_next = released_run_reg + bdpc_pkg::RUN_W'(1);
                    if (released_run_next == bdpc_pkg::RUN_TARGET)
                    begin
                        level_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_run_reg  <= '0;
            released_run_reg <= '0;
            level_reg        <= 1'b0;
        end
        else
        begin
            pressed_run_reg  <= pressed_run_next;
            released_run_reg <= released_run_next;
            level_reg        <= level_next;
        end
    end

    assign status.level = level_next;
    assign status.press = press;
endmodule

/* rtl/bdpc_tally.sv */
// Saturating press tally with clamped decrease.
// Depends on bdpc_pkg.
module bdpc_tally (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic                         count_mode,
    input  bdpc_pkg::item_t              item,
    input  bdpc_pkg::deb_status_t        status,
    output logic [bdpc_pkg::TALLY_W-1:0] tally,
    output logic                         step
);
    logic [bdpc_pkg::TALLY_W-1:0] tally_reg;
    logic [bdpc_pkg::TALLY_W-1:0] tally_next;
    logic                         shrink;

    assign shrink = fire && (item.kind == bdpc_pkg::KIND_DECREASE);

    always_comb
    begin
        tally_next = tally_reg;
        if (shrink)
        begin
            if (item.decrease_amount > bdpc_pkg::AMT_W'(tally_reg))
            begin
                tally_next = '0;
            end
            else
            begin
                tally_next = tally_reg - item.decrease_amount[bdpc_pkg::TALLY_W-1:0];
            end
        end
        else if (status.press && count_mode && (tally_reg < bdpc_pkg::TALLY_CAP))
        begin
            tally_next = tally_reg + bdpc_pkg::TALLY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
        end
        else
        begin
            tally_reg <= tally_next;
        end
    end

    assign tally = tally_next;
    assign step  = status.press && !count_mode;
endmodule

/* rtl/button_debounce_press_counter.sv */
// Push-button debouncer with press counter, top level.
// Depends on bdpc_pkg, the channel interfaces, bdpc_in_stage, bdpc_debounce,
// bdpc_tally and button_debounce_press_counter_defines.svh.
//
// Use: cmd takes one item per handshake, either a pin sample tick (kind 0)
// or a tally decrease (kind 1). Every item gives exactly one item on result:
// the debounced level, the press count and a one-result brightness step.
// cfg writes the count_mode bit and is always ready. The user must write count_mode
// only while idle; the block itself does not enforce this.
// Throughput: one item per cycle while result is not stalled, held by the input
// register feeding one level of counter logic into the result register.
// A stalled result keeps its item; cmd keeps accepting until the input
// register is also full, then ready drops until result is taken.
// Reset clears both run counters, the debounced level (released), the
// press count and count_mode, and empties both registers.
`include "button_debounce_press_counter_defines.svh"

module button_debounce_press_counter (
    input  logic      clk,
    input  logic      rst_n,
    bdpc_in_if.sink   cmd,
    bdpc_out_if.source result,
    bdpc_cfg_if.sink  cfg
);
    logic                         count_mode_reg;
    logic                         advance;
    logic                         item_valid;
    logic                         fire;
    bdpc_pkg::item_t              item;
    bdpc_pkg::deb_status_t        status;
    logic [bdpc_pkg::TALLY_W-1:0] tally;
    logic                         step;
    logic                         res_valid_reg;
    logic                         level_reg;
    logic [bdpc_pkg::TALLY_W-1:0] count_reg;
    logic                         step_reg;

    assign cfg.ready = 1'b1;
    assign advance   = !res_valid_reg || result.ready;
    assign fire      = advance && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_mode_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            count_mode_reg <= cfg.count_mode;
        end
    end

    bdpc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bdpc_debounce u_debounce (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .status (status)
    );

    bdpc_tally u_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .count_mode (count_mode_reg),
        .item       (item),
        .status     (status),
        .tally      (tally),
        .step       (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_reg <= status.level;
            count_reg <= tally;
            step_reg  <= step;
        end
    end

    assign result.valid             = res_valid_reg;
    assign result.debounced_pressed = level_reg;
    assign result.press_count       = count_reg;
    assign result.brightness_step   = step_reg;

    `BDPC_ASSERT_IMPLY(a_step_means_pressed, clk, rst_n,
        result.valid && result.brightness_step, result.debounced_pressed)
    `BDPC_ASSERT_IMPLY(a_count_capped, clk, rst_n,
        result.valid, result.press_count <= bdpc_pkg::TALLY_CAP)
    `BDPC_ASSERT_NEXT(a_held_item_kept, clk, rst_n,
        item_valid && !advance, item_valid && $stable(item))
endmodule
